// ===== design/bstk_pkg.sv =====
// Package for the bounded stack block: request and status codes, data word
// type and the scan accumulator shared by the top level and the scan unit.
// No dependencies.
package bstk_pkg;

  localparam int WORD_W = 32;
  localparam int CODE_W = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CODE_W-1:0] code_t;

  // Request kinds
  localparam code_t REQ_PUSH   = 3'd0;
  localparam code_t REQ_POP    = 3'd1;
  localparam code_t REQ_PEEK   = 3'd2;
  localparam code_t REQ_LIST   = 3'd3;
  localparam code_t REQ_SECOND = 3'd4;

  // Result status codes
  localparam code_t ST_OK       = 3'd0;
  localparam code_t ST_OVERFLOW = 3'd1;
  localparam code_t ST_EMPTY    = 3'd2;
  localparam code_t ST_FEW      = 3'd3;
  localparam code_t ST_NONE     = 3'd4;

  // Running state of the second-largest scan
  typedef struct packed {
    word_t big;
    word_t second;
    logic  found;
  } scan_acc_t;

endpackage

// ===== design/bstk_if.sv =====
// Valid/ready channel interfaces for stack requests and stack results.
// Depends on bstk_pkg for the payload types.
interface bstk_req_if;
  logic               valid;
  logic               ready;
  bstk_pkg::code_t    req_type;
  bstk_pkg::word_t    push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface bstk_rsp_if;
  logic               valid;
  logic               ready;
  bstk_pkg::code_t    status;
  bstk_pkg::word_t    value;
  logic               last;

  modport source (output valid, output status, output value, output last, input ready);
  modport sink (input valid, input status, input value, input last, output ready);
endinterface

// ===== design/bounded_stack_with_second_max.sv =====
// Bounded LIFO of signed 32-bit words with pop, peek, list and second-largest.
// Push: result in the cycle after accept. Pop/peek: RAM read, then S_TOP.
// List: entries top first, each held in S_OUT until accepted. Second largest:
// S_SCAN0 loads the bottom entry, then one RAM read and one compare per cycle.
// One request at a time; the next is taken from the cycle after the final
// result is accepted. Reset empties the stack; stored words are not cleared.
module bounded_stack_with_second_max #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  bstk_req_if.sink       req,
  bstk_rsp_if.source     rsp
);
  import bstk_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_LIST,
    S_SCAN0,
    S_SCAN,
    S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_m1;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] ptr_next;
  logic             do_pop;
  logic             full;
  logic             empty;
  logic             in_acc;
  logic             out_acc;
  logic             ram_we;
  word_t            rdata;
  scan_acc_t        acc;
  scan_acc_t        acc_next;

  logic             out_valid;
  code_t            out_status;
  word_t            out_value;
  logic             out_last;

  assign fill_m1 = fill - CNT_W'(1);
  assign top_idx = fill_m1[IDX_W-1:0];
  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);

  assign req.ready  = (state == S_IDLE);
  assign in_acc     = req.valid && req.ready;
  assign out_acc    = out_valid && rsp.ready;

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.value  = out_value;
  assign rsp.last   = out_last;

  // Store a pushed word when there is room
  assign ram_we = in_acc && (req.req_type == REQ_PUSH) && !full;

  bstk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[IDX_W-1:0]),
    .wdata (req.push_value),
    .raddr (ptr_next),
    .rdata (rdata)
  );

  bstk_scan u_scan (
    .acc      (acc),
    .v        (rdata),
    .acc_next (acc_next)
  );

  // Read pointer: the RAM is addressed with the next pointer so data lines up
  always_comb begin
    ptr_next = ptr;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (req.req_type)
            REQ_POP, REQ_PEEK, REQ_LIST: ptr_next = top_idx;
            REQ_SECOND:                  ptr_next = '0;
            default:                     ptr_next = ptr;
          endcase
        end
      end
      S_SCAN0: ptr_next = ptr + IDX_W'(1);
      S_SCAN: begin
        if (ptr != top_idx) begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      S_OUT: begin
        if (out_acc && !out_last) begin
          ptr_next = ptr - IDX_W'(1);
        end
      end
      default: ptr_next = ptr;
    endcase
  end

  // Sequencer: state, fill count and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      ptr <= ptr_next;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            out_value <= '0;
            out_last  <= 1'b1;
            do_pop    <= (req.req_type == REQ_POP);
            case (req.req_type)
              REQ_PUSH: begin
                out_valid  <= 1'b1;
                state      <= S_OUT;
                out_status <= full ? ST_OVERFLOW : ST_OK;
                if (!full) begin
                  fill <= fill + CNT_W'(1);
                end
              end
              REQ_POP, REQ_PEEK: begin
                if (empty) begin
                  out_status <= ST_EMPTY;
                  out_valid  <= 1'b1;
                  state      <= S_OUT;
                end else begin
                  state <= S_TOP;
                end
              end
              REQ_LIST: begin
                if (empty) begin
                  out_status <= ST_EMPTY;
                  out_valid  <= 1'b1;
                  state      <= S_OUT;
                end else begin
                  state <= S_LIST;
                end
              end
              REQ_SECOND: begin
                if (fill < CNT_W'(2)) begin
                  out_status <= ST_FEW;
                  out_valid  <= 1'b1;
                  state      <= S_OUT;
                end else begin
                  state <= S_SCAN0;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TOP: begin
          out_status <= ST_OK;
          out_value  <= rdata;
          out_last   <= 1'b1;
          out_valid  <= 1'b1;
          state      <= S_OUT;
          if (do_pop) begin
            fill <= fill_m1;
          end
        end
        S_LIST: begin
          out_status <= ST_OK;
          out_value  <= rdata;
          out_last   <= (ptr == '0);
          out_valid  <= 1'b1;
          state      <= S_OUT;
        end
        S_SCAN0: begin
          acc.big    <= rdata;
          acc.second <= '0;
          acc.found  <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          acc <= acc_next;
          if (ptr == top_idx) begin
            out_status <= acc_next.found ? ST_OK : ST_NONE;
            out_value  <= acc_next.found ? acc_next.second : '0;
            out_last   <= 1'b1;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            state     <= out_last ? S_IDLE : S_LIST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Fill count stays within the stack depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // No new request is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request accepted with result pending");

  // A push into a non-full stack grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (in_acc && req.req_type == REQ_PUSH && !full) |=> fill == $past(fill) + CNT_W'(1))
    else $error("push did not grow the stack");

  // Error results are single, final and carry a zero value
  a_err_final: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.last && rsp.value == '0))
    else $error("error result not final or nonzero");

  // A pop that returns data shrinks the stack by one
  a_pop_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOP && do_pop) |=> fill == $past(fill) - CNT_W'(1))
    else $error("pop did not shrink the stack");

endmodule

// ===== design/bstk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bstk_scan.sv =====
// Compare unit for the second-largest scan: folds one stored word into
// the running maximum / runner-up. Depends on bstk_pkg.
module bstk_scan (
  input  bstk_pkg::scan_acc_t acc,
  input  bstk_pkg::word_t     v,
  output bstk_pkg::scan_acc_t acc_next
);
  import bstk_pkg::*;

  logic above_big;
  logic below_big;
  logic above_second;

  // Signed compares against the current maximum and runner-up
  assign above_big    = $signed(v) > $signed(acc.big);
  assign below_big    = $signed(v) < $signed(acc.big);
  assign above_second = $signed(v) > $signed(acc.second);

  // Update: a new maximum demotes the old one; otherwise improve runner-up
  always_comb begin
    acc_next = acc;
    if (above_big) begin
      acc_next.second = acc.big;
      acc_next.big    = v;
      acc_next.found  = 1'b1;
    end else if (below_big && (!acc.found || above_second)) begin
      acc_next.second = v;
      acc_next.found  = 1'b1;
    end
  end

endmodule
